FILE: sv/mlrd_pkg.sv
// Shared types and constants of the mutation log record deframer.
`timescale 1ns / 1ps
`default_nettype none

package mlrd_pkg;

  localparam int unsigned RECORD_HEADER_BYTES = 12;
  localparam logic [63:0] MIN_VERSION_RESET = 64'h0FDB_00A2_0009_0001;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam int unsigned TDATA_W = 112;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_KEY    = 2'd1,
    KIND_VALUE  = 2'd2,
    KIND_STATUS = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_VERSION = 3'd1,
    ST_MISSING     = 3'd2,
    ST_MISMATCH    = 3'd3,
    ST_EXTRA       = 3'd4
  } status_e;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] mutation_type;
    logic [31:0] key_length;
    logic [31:0] value_length;
    logic [7:0]  payload_byte;
    status_e     status;
    logic        final_result;
  } result_t;

  localparam result_t RESULT_NONE = '{
    kind: KIND_HEADER, mutation_type: 32'd0, key_length: 32'd0, value_length: 32'd0,
    payload_byte: 8'd0, status: ST_OK, final_result: 1'b0
  };

endpackage

`default_nettype wire

FILE: sv/mutation_log_record_deframer.sv
// Top level of the mutation log record deframer: byte parser and result output.
//
// Channel   Direction  Transfer condition               Contents
// s_axis    in         s_axis_tvalid & s_axis_tready    one byte of the log value, tlast on final
// m_axis    out        m_axis_tvalid & m_axis_tready    header, key/value byte or end status
// cfg       in         cfg_we_i                         highest rejected protocol version
//
// Each byte is parsed in its transfer cycle; one is taken per cycle while the queue has room.
// A byte yields at most two results, which go into a four-entry result queue; input is
// taken while the queue has room for two, so a stalled output holds the input off.
// The byte that carries tlast also yields the end status, after any result of its own.
// Reset clears the parser and the queue and loads the default minimum version.
`timescale 1ns / 1ps
`default_nettype none

module mutation_log_record_deframer (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          cfg_we_i,
  input  wire  [63:0]  cfg_wdata_i,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  input  wire  [7:0]   s_axis_tdata,   // data_byte[7:0]
  input  wire          s_axis_tlast,
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  output logic [111:0] m_axis_tdata,   // mutation_type[31:0], key_length[63:32],
                                       // value_length[95:64], payload_byte[103:96],
                                       // status[106:104], zeros[111:107]
  output logic [1:0]   m_axis_tuser,   // kind[1:0]
  output logic         m_axis_tlast
);

  typedef enum logic [2:0] {
    PH_VERSION,
    PH_TOTAL,
    PH_HEADER,
    PH_KEY,
    PH_VALUE,
    PH_TRAIL,
    PH_ERROR
  } phase_e;

  phase_e               phase_q, phase_d;
  logic [3:0]           cnt_q, cnt_d;
  logic [63:0]          shift_q, shift_d;
  logic [31:0]          total_q, total_d;
  logic [33:0]          consumed_q, consumed_d;
  logic [33:0]          rx_q, rx_d;
  logic [31:0]          rkind_q, rkind_d;
  logic [31:0]          len1_q, len1_d;
  logic [31:0]          len2_q, len2_d;
  logic [31:0]          left_q, left_d;
  mlrd_pkg::status_e    err_q, err_d;
  logic [63:0]          min_q;

  logic                 in_fire;
  logic [63:0]          shift64;
  logic [31:0]          word32;
  logic [31:0]          left_dec;
  logic                 do_finish;
  logic [33:0]          finish_consumed;
  logic                 push0, push1, space;
  mlrd_pkg::result_t    res0, res1, status_res, head;
  mlrd_pkg::status_e    st;

  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = space;
  assign shift64       = {s_axis_tdata, shift_q[63:8]};
  assign word32        = {s_axis_tdata, shift_q[31:8]};
  assign left_dec      = (left_q != 32'd0) ? (left_q - 32'd1) : left_q;

  always_comb begin
    phase_d         = phase_q;
    cnt_d           = cnt_q;
    shift_d         = shift_q;
    total_d         = total_q;
    consumed_d      = consumed_q;
    rx_d            = rx_q;
    rkind_d         = rkind_q;
    len1_d          = len1_q;
    len2_d          = len2_q;
    left_d          = left_q;
    err_d           = err_q;
    push0           = 1'b0;
    push1           = 1'b0;
    res0            = mlrd_pkg::RESULT_NONE;
    res1            = mlrd_pkg::RESULT_NONE;
    status_res      = mlrd_pkg::RESULT_NONE;
    do_finish       = 1'b0;
    finish_consumed = consumed_q;
    st              = mlrd_pkg::ST_OK;

    if (in_fire) begin
      case (phase_q)
        PH_VERSION: begin
          cnt_d   = cnt_q + 4'd1;
          shift_d = shift64;
          if (cnt_q == 4'd7) begin
            if (shift64 <= min_q) begin
              phase_d = PH_ERROR;
              err_d   = mlrd_pkg::ST_BAD_VERSION;
            end else begin
              phase_d = PH_TOTAL;
            end
            cnt_d   = 4'd0;
            shift_d = 64'd0;
          end
        end
        PH_TOTAL: begin
          cnt_d   = cnt_q + 4'd1;
          shift_d = {32'd0, word32};
          if (cnt_q == 4'd3) begin
            total_d    = word32;
            cnt_d      = 4'd0;
            shift_d    = 64'd0;
            consumed_d = 34'd0;
            phase_d    = (word32 == 32'd0) ? PH_TRAIL : PH_HEADER;
          end
        end
        PH_HEADER: begin
          rx_d    = rx_q + 34'd1;
          cnt_d   = cnt_q + 4'd1;
          shift_d = {32'd0, word32};
          if (cnt_q[1:0] == 2'd3) begin
            shift_d = 64'd0;
          end
          if (cnt_q == 4'd3) begin
            rkind_d = word32;
          end
          if (cnt_q == 4'd7) begin
            len1_d = word32;
          end
          if (cnt_q == 4'(mlrd_pkg::RECORD_HEADER_BYTES - 1)) begin
            len2_d              = word32;
            cnt_d               = 4'd0;
            push0               = 1'b1;
            res0.kind           = mlrd_pkg::KIND_HEADER;
            res0.mutation_type  = rkind_q;
            res0.key_length     = len1_q;
            res0.value_length   = word32;
            consumed_d = consumed_q + 34'(mlrd_pkg::RECORD_HEADER_BYTES)
                         + {2'b00, len1_q} + {2'b00, word32};
            if (len1_q != 32'd0) begin
              left_d  = len1_q;
              phase_d = PH_KEY;
            end else if (word32 != 32'd0) begin
              left_d  = word32;
              phase_d = PH_VALUE;
            end else begin
              do_finish       = 1'b1;
              finish_consumed = consumed_d;
            end
          end
        end
        PH_KEY: begin
          rx_d              = rx_q + 34'd1;
          push0             = 1'b1;
          res0.kind         = mlrd_pkg::KIND_KEY;
          res0.payload_byte = s_axis_tdata;
          left_d            = left_dec;
          if (left_dec == 32'd0) begin
            if (len2_q != 32'd0) begin
              left_d  = len2_q;
              phase_d = PH_VALUE;
            end else begin
              do_finish = 1'b1;
            end
          end
        end
        PH_VALUE: begin
          rx_d              = rx_q + 34'd1;
          push0             = 1'b1;
          res0.kind         = mlrd_pkg::KIND_VALUE;
          res0.payload_byte = s_axis_tdata;
          left_d            = left_dec;
          if (left_dec == 32'd0) begin
            do_finish = 1'b1;
          end
        end
        PH_TRAIL: begin
          phase_d = PH_ERROR;
          err_d   = mlrd_pkg::ST_EXTRA;
        end
        default: begin
        end
      endcase

      if (do_finish) begin
        if (finish_consumed > {2'b00, total_q}) begin
          phase_d = PH_ERROR;
          err_d   = mlrd_pkg::ST_MISMATCH;
        end else if (finish_consumed == {2'b00, total_q}) begin
          phase_d = PH_TRAIL;
        end else begin
          phase_d = PH_HEADER;
        end
      end

      if (s_axis_tlast) begin
        case (phase_d)
          PH_VERSION, PH_TOTAL: st = mlrd_pkg::ST_MISSING;
          PH_HEADER, PH_KEY, PH_VALUE: begin
            st = (rx_d < {2'b00, total_d}) ? mlrd_pkg::ST_MISSING : mlrd_pkg::ST_MISMATCH;
          end
          PH_TRAIL: st = mlrd_pkg::ST_OK;
          default:  st = err_d;
        endcase
        status_res.kind         = mlrd_pkg::KIND_STATUS;
        status_res.status       = st;
        status_res.final_result = 1'b1;
        if (push0) begin
          push1 = 1'b1;
          res1  = status_res;
        end else begin
          push0 = 1'b1;
          res0  = status_res;
        end
        phase_d    = PH_VERSION;
        cnt_d      = 4'd0;
        shift_d    = 64'd0;
        total_d    = 32'd0;
        consumed_d = 34'd0;
        rx_d       = 34'd0;
        rkind_d    = 32'd0;
        len1_d     = 32'd0;
        len2_d     = 32'd0;
        left_d     = 32'd0;
        err_d      = mlrd_pkg::ST_OK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_VERSION;
      cnt_q      <= 4'd0;
      shift_q    <= 64'd0;
      total_q    <= 32'd0;
      consumed_q <= 34'd0;
      rx_q       <= 34'd0;
      rkind_q    <= 32'd0;
      len1_q     <= 32'd0;
      len2_q     <= 32'd0;
      left_q     <= 32'd0;
      err_q      <= mlrd_pkg::ST_OK;
      min_q      <= mlrd_pkg::MIN_VERSION_RESET;
    end else begin
      phase_q    <= phase_d;
      cnt_q      <= cnt_d;
      shift_q    <= shift_d;
      total_q    <= total_d;
      consumed_q <= consumed_d;
      rx_q       <= rx_d;
      rkind_q    <= rkind_d;
      len1_q     <= len1_d;
      len2_q     <= len2_d;
      left_q     <= left_d;
      err_q      <= err_d;
      if (cfg_we_i) begin
        min_q <= cfg_wdata_i;
      end
    end
  end

  mlrd_result_fifo u_result_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push0_i (push0),
    .push1_i (push1),
    .data0_i (res0),
    .data1_i (res1),
    .space_o (space),
    .valid_o (m_axis_tvalid),
    .pop_i   (m_axis_tready),
    .head_o  (head)
  );

  assign m_axis_tdata = {5'd0, head.status, head.payload_byte, head.value_length,
                         head.key_length, head.mutation_type};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.final_result;

endmodule

`default_nettype wire

FILE: sv/mlrd_result_fifo.sv
// Result queue that takes up to two results per cycle and hands out one per cycle while popped.
`timescale 1ns / 1ps
`default_nettype none

module mlrd_result_fifo (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     push0_i,
  input  wire                     push1_i,
  input  wire mlrd_pkg::result_t  data0_i,
  input  wire mlrd_pkg::result_t  data1_i,
  output logic                    space_o,
  output logic                    valid_o,
  input  wire                     pop_i,
  output mlrd_pkg::result_t       head_o
);

  mlrd_pkg::result_t mem_q [mlrd_pkg::FIFO_DEPTH];

  logic [mlrd_pkg::FIFO_PTR_W-1:0] wr_q, wr_d, rd_q, rd_d, wr_next;
  logic [mlrd_pkg::FIFO_CNT_W-1:0] count_q, count_d;
  logic                            do_pop;

  assign wr_next = wr_q + mlrd_pkg::FIFO_PTR_W'(1);
  assign do_pop  = pop_i && (count_q != '0);
  assign valid_o = count_q != '0;
  assign space_o = count_q <= mlrd_pkg::FIFO_CNT_W'(mlrd_pkg::FIFO_DEPTH - 2);
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d    = wr_q;
    rd_d    = rd_q;
    count_d = count_q;
    if (push0_i) begin
      wr_d    = wr_d + mlrd_pkg::FIFO_PTR_W'(1);
      count_d = count_d + mlrd_pkg::FIFO_CNT_W'(1);
    end
    if (push1_i) begin
      wr_d    = wr_d + mlrd_pkg::FIFO_PTR_W'(1);
      count_d = count_d + mlrd_pkg::FIFO_CNT_W'(1);
    end
    if (do_pop) begin
      rd_d    = rd_q + mlrd_pkg::FIFO_PTR_W'(1);
      count_d = count_d - mlrd_pkg::FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push0_i) begin
      mem_q[wr_q] <= data0_i;
    end
    if (push1_i) begin
      mem_q[wr_next] <= data1_i;
    end
  end

endmodule

`default_nettype wire
